// ===== design/rcsas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC stick arming sequencer package
// Shared types, codes and constants for the arming sequencer.
// ----------------------------------------------------------------------------
package rcsas_pkg;

	localparam int unsigned NUM_MODES = 4;

	localparam int unsigned THR_W   = 15;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned STICK_W = 16;
	localparam int unsigned MODE_W  = 8;
	localparam int unsigned CMODE_W = 4;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFGI_W  = 2;

	localparam logic [THR_W-1:0]  THR_RESET    = 15'd819;
	localparam logic [HOLD_W-1:0] ARM_RESET    = 16'd5000;
	localparam logic [HOLD_W-1:0] DISARM_RESET = 16'd2000;

	localparam logic [CFGI_W-1:0] CFG_STICK_THR  = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_ARM_HOLD   = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_DISARM_HOLD = 2'd2;

	typedef enum logic [3:0] {
		STG_CHECK = 4'b0001,
		STG_WAIT  = 4'b0010,
		STG_FIRST = 4'b0100,
		STG_RUN   = 4'b1000
	} stage_t;

	localparam logic [1:0] STAGE_CODE_CHECK = 2'd0;
	localparam logic [1:0] STAGE_CODE_WAIT  = 2'd1;
	localparam logic [1:0] STAGE_CODE_FIRST = 2'd2;
	localparam logic [1:0] STAGE_CODE_RUN   = 2'd3;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_RESET  = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;

	localparam logic [1:0] WAIT_NONE   = 2'd0;
	localparam logic [1:0] WAIT_ODOM   = 2'd1;
	localparam logic [1:0] WAIT_ARMST  = 2'd2;
	localparam logic [1:0] WAIT_PREARM = 2'd3;

	typedef struct packed {
		logic [THR_W-1:0]  stick_threshold;
		logic [HOLD_W-1:0] arm_hold_ms;
		logic [HOLD_W-1:0] disarm_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic                      rc_enable;
		logic [STAMP_W-1:0]        stamp_ms;
		logic signed [STICK_W-1:0] roll;
		logic signed [STICK_W-1:0] pitch;
		logic signed [STICK_W-1:0] yaw;
		logic signed [STICK_W-1:0] throttle;
		logic [MODE_W-1:0]         mode_request;
		logic                      odom_ready;
		logic                      arm_status_known;
		logic                      armed;
		logic                      prearm_known;
		logic                      prearm_ok;
	} frame_t;

	typedef struct packed {
		stage_t               stage;
		logic [STAMP_W-1:0]   arm_start;
		logic [STAMP_W-1:0]   disarm_start;
		logic [CMODE_W-1:0]   last_mode;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]         stage;
		logic               arm_request;
		logic               arm_request_value;
		logic [1:0]         controller_action;
		logic [CMODE_W-1:0] controller_mode;
		logic               mode_invalid;
		logic               arm_gesture;
		logic               disarm_gesture;
		logic [1:0]         waiting_for;
	} result_t;

endpackage

// ===== design/rcsas_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC stick arming sequencer step logic
// Computes the next sequencer state and the result word for one frame.
// ----------------------------------------------------------------------------
module rcsas_step #(
	parameter int unsigned NUM_MODES = rcsas_pkg::NUM_MODES
) (
	input  rcsas_pkg::cfg_t       cfg,
	input  rcsas_pkg::frame_t     frm,
	input  rcsas_pkg::seq_state_t st,
	output rcsas_pkg::seq_state_t st_nxt,
	output rcsas_pkg::result_t    res
);

	localparam logic signed [17:0] Q_ONE = 18'sd16384;

	logic signed [17:0] thr_e;
	logic signed [17:0] roll_e;
	logic signed [17:0] pitch_e;
	logic signed [17:0] yaw_e;
	logic signed [17:0] thrs_e;
	logic signed [17:0] roll_abs;
	logic signed [17:0] pitch_abs;
	logic               centred;
	logic               throttle_low;
	logic               arm_g;
	logic               disarm_g;
	logic [31:0]        arm_elapsed;
	logic [31:0]        disarm_elapsed;
	logic               arm_expired;
	logic               disarm_expired;
	logic               mode_bad;
	logic [3:0]         mode_lo;

	assign thr_e   = $signed({3'b000, cfg.stick_threshold});
	assign roll_e  = 18'($signed(frm.roll));
	assign pitch_e = 18'($signed(frm.pitch));
	assign yaw_e   = 18'($signed(frm.yaw));
	assign thrs_e  = 18'($signed(frm.throttle));

	assign roll_abs  = roll_e[17] ? -roll_e : roll_e;
	assign pitch_abs = pitch_e[17] ? -pitch_e : pitch_e;

	assign centred      = (roll_abs < thr_e) && (pitch_abs < thr_e);
	assign throttle_low = thrs_e < (thr_e - Q_ONE);
	assign arm_g        = centred && throttle_low && (yaw_e < (thr_e - Q_ONE));
	assign disarm_g     = centred && throttle_low && (yaw_e > (Q_ONE - thr_e));

	assign arm_elapsed    = frm.stamp_ms - st.arm_start;
	assign disarm_elapsed = frm.stamp_ms - st.disarm_start;
	assign arm_expired    = arm_elapsed > {16'd0, cfg.arm_hold_ms};
	assign disarm_expired = disarm_elapsed > {16'd0, cfg.disarm_hold_ms};

	assign mode_bad = frm.mode_request >= 8'(NUM_MODES);
	assign mode_lo  = frm.mode_request[3:0];

	always_comb begin
		st_nxt                = st;
		res                   = '0;
		res.controller_action = rcsas_pkg::ACT_NONE;
		res.waiting_for       = rcsas_pkg::WAIT_NONE;
		if (!frm.rc_enable) begin
			st_nxt.stage = rcsas_pkg::STG_CHECK;
		end else begin
			unique case (st.stage)
				rcsas_pkg::STG_CHECK: begin
					if (!frm.odom_ready) begin
						res.waiting_for = rcsas_pkg::WAIT_ODOM;
					end else if (!frm.arm_status_known) begin
						res.waiting_for = rcsas_pkg::WAIT_ARMST;
					end else if (!frm.prearm_known) begin
						res.waiting_for = rcsas_pkg::WAIT_PREARM;
					end else begin
						st_nxt.arm_start = frm.stamp_ms;
						st_nxt.stage     = rcsas_pkg::STG_WAIT;
					end
				end
				rcsas_pkg::STG_WAIT: begin
					if (frm.armed) begin
						st_nxt.stage = rcsas_pkg::STG_FIRST;
					end else if (arm_expired) begin
						res.arm_request       = 1'b1;
						res.arm_request_value = 1'b1;
						st_nxt.arm_start      = frm.stamp_ms;
					end else begin
						res.arm_gesture = arm_g;
						if (!(arm_g && frm.prearm_ok)) begin
							st_nxt.arm_start = frm.stamp_ms;
						end
					end
				end
				rcsas_pkg::STG_FIRST: begin
					if (mode_bad) begin
						res.mode_invalid = 1'b1;
					end else begin
						res.controller_action = rcsas_pkg::ACT_RESET;
						res.controller_mode   = mode_lo;
						st_nxt.last_mode      = mode_lo;
						st_nxt.disarm_start   = frm.stamp_ms;
						st_nxt.stage          = rcsas_pkg::STG_RUN;
					end
				end
				rcsas_pkg::STG_RUN: begin
					if (!frm.armed) begin
						st_nxt.stage = rcsas_pkg::STG_WAIT;
					end else if (disarm_g) begin
						res.disarm_gesture = 1'b1;
						if (disarm_expired) begin
							res.arm_request     = 1'b1;
							st_nxt.disarm_start = frm.stamp_ms;
						end
					end else begin
						st_nxt.disarm_start = frm.stamp_ms;
						if (mode_bad) begin
							res.mode_invalid = 1'b1;
						end else if (mode_lo != st.last_mode) begin
							st_nxt.last_mode      = mode_lo;
							res.controller_action = rcsas_pkg::ACT_RESET;
							res.controller_mode   = mode_lo;
						end else begin
							res.controller_action = rcsas_pkg::ACT_UPDATE;
							res.controller_mode   = mode_lo;
						end
					end
				end
				default: begin
					st_nxt.stage = rcsas_pkg::STG_CHECK;
				end
			endcase
		end

		unique case (st_nxt.stage)
			rcsas_pkg::STG_CHECK: res.stage = rcsas_pkg::STAGE_CODE_CHECK;
			rcsas_pkg::STG_WAIT:  res.stage = rcsas_pkg::STAGE_CODE_WAIT;
			rcsas_pkg::STG_FIRST: res.stage = rcsas_pkg::STAGE_CODE_FIRST;
			rcsas_pkg::STG_RUN:   res.stage = rcsas_pkg::STAGE_CODE_RUN;
			default:              res.stage = rcsas_pkg::STAGE_CODE_CHECK;
		endcase
	end

endmodule

// ===== design/rc_stick_arming_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC stick arming sequencer unit
// Arming and controller sequencing from RC frames, one result word per frame.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    one RC frame (timestamp, sticks, mode, flags)
//  out      out_valid / out_stall  stage, arm request, controller action, status
//  cfg      cfg_we                 cfg_index, cfg_wdata (threshold, hold times)
//
// A frame is captured in the input register and its result word is registered in
// the output register, so one word can be taken every cycle while the output is
// not stalled. The sequencer state is updated as the frame moves from
// the input register to the output register. Reset clears the state and loads
// the default configuration. A stall on the output holds both registers.
// ----------------------------------------------------------------------------
module rc_stick_arming_sequencer_unit #(
	parameter int unsigned NUM_MODES = rcsas_pkg::NUM_MODES
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                rc_enable,
	input  logic [31:0]         stamp_ms,
	input  logic signed [15:0]  roll,
	input  logic signed [15:0]  pitch,
	input  logic signed [15:0]  yaw,
	input  logic signed [15:0]  throttle,
	input  logic [7:0]          mode_request,
	input  logic                odom_ready,
	input  logic                arm_status_known,
	input  logic                armed,
	input  logic                prearm_known,
	input  logic                prearm_ok,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          stage,
	output logic                arm_request,
	output logic                arm_request_value,
	output logic [1:0]          controller_action,
	output logic [3:0]          controller_mode,
	output logic                mode_invalid,
	output logic                arm_gesture,
	output logic                disarm_gesture,
	output logic [1:0]          waiting_for,

	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);

	rcsas_pkg::cfg_t       cfg_q;
	rcsas_pkg::frame_t     frm_s1;
	logic                  vld_s1;
	rcsas_pkg::result_t    res_s2;
	logic                  vld_s2;
	rcsas_pkg::seq_state_t st_q;
	rcsas_pkg::seq_state_t st_nxt;
	rcsas_pkg::result_t    res_nxt;
	logic                  adv;
	logic                  take;

	assign adv      = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_threshold <= rcsas_pkg::THR_RESET;
			cfg_q.arm_hold_ms     <= rcsas_pkg::ARM_RESET;
			cfg_q.disarm_hold_ms  <= rcsas_pkg::DISARM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcsas_pkg::CFG_STICK_THR:   cfg_q.stick_threshold <= cfg_wdata[14:0];
				rcsas_pkg::CFG_ARM_HOLD:    cfg_q.arm_hold_ms     <= cfg_wdata;
				rcsas_pkg::CFG_DISARM_HOLD: cfg_q.disarm_hold_ms  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frm_s1.rc_enable        <= rc_enable;
			frm_s1.stamp_ms         <= stamp_ms;
			frm_s1.roll             <= roll;
			frm_s1.pitch            <= pitch;
			frm_s1.yaw              <= yaw;
			frm_s1.throttle         <= throttle;
			frm_s1.mode_request     <= mode_request;
			frm_s1.odom_ready       <= odom_ready;
			frm_s1.arm_status_known <= arm_status_known;
			frm_s1.armed            <= armed;
			frm_s1.prearm_known     <= prearm_known;
			frm_s1.prearm_ok        <= prearm_ok;
		end
		if (vld_s1 && adv) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1          <= 1'b0;
			vld_s2          <= 1'b0;
			st_q.stage        <= rcsas_pkg::STG_CHECK;
			st_q.arm_start    <= '0;
			st_q.disarm_start <= '0;
			st_q.last_mode    <= '0;
		end else begin
			if (adv) begin
				vld_s2 <= vld_s1;
			end
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (vld_s1 && adv) begin
				st_q <= st_nxt;
			end
		end
	end

	rcsas_step #(
		.NUM_MODES (NUM_MODES)
	) u_step (
		.cfg    (cfg_q),
		.frm    (frm_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	assign out_valid         = vld_s2;
	assign stage             = res_s2.stage;
	assign arm_request       = res_s2.arm_request;
	assign arm_request_value = res_s2.arm_request_value;
	assign controller_action = res_s2.controller_action;
	assign controller_mode   = res_s2.controller_mode;
	assign mode_invalid      = res_s2.mode_invalid;
	assign arm_gesture       = res_s2.arm_gesture;
	assign disarm_gesture    = res_s2.disarm_gesture;
	assign waiting_for       = res_s2.waiting_for;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC stick arming sequencer testbench
// Drives RC frames through the sequencer unit with random idle and stall
// bursts, predicts every result word from its own model of the four-stage
// sequencer and checks each word field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
	import rcsas_pkg::*;

	localparam int Q_ONE = 16384;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 60;

	// Status flags in the order odom, arm status known, armed, pre-arm known, pre-arm ok.
	localparam logic [4:0] FL_NONE     = 5'b00000;
	localparam logic [4:0] FL_NO_ODOM  = 5'b01011;
	localparam logic [4:0] FL_NO_ARMST = 5'b10011;
	localparam logic [4:0] FL_NO_PRE   = 5'b11001;
	localparam logic [4:0] FL_READY    = 5'b11011;
	localparam logic [4:0] FL_PRE_FAIL = 5'b11010;
	localparam logic [4:0] FL_ARMED    = 5'b11111;

	logic clk;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	frame_t frm = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] stage;
	logic arm_request;
	logic arm_request_value;
	logic [1:0] controller_action;
	logic [3:0] controller_mode;
	logic mode_invalid;
	logic arm_gesture;
	logic disarm_gesture;
	logic [1:0] waiting_for;

	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	frame_t frame_q[$];
	result_t result_words_due[$];

	logic [THR_W-1:0] thr_cfg = THR_RESET;
	logic [HOLD_W-1:0] arm_hold_cfg = ARM_RESET;
	logic [HOLD_W-1:0] disarm_hold_cfg = DISARM_RESET;

	logic [1:0] sq_stage = STAGE_CODE_CHECK;
	logic [31:0] sq_arm_t0 = '0;
	logic [31:0] sq_disarm_t0 = '0;
	logic [3:0] sq_last_mode = '0;

	logic [31:0] g_stamp = '0;
	logic g_armed = 1'b0;
	logic [7:0] g_mode = '0;
	int g_kind = 0;

	bit in_fire = 1'b0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int ph;

	rc_stick_arming_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rc_enable(frm.rc_enable),
		.stamp_ms(frm.stamp_ms),
		.roll(frm.roll),
		.pitch(frm.pitch),
		.yaw(frm.yaw),
		.throttle(frm.throttle),
		.mode_request(frm.mode_request),
		.odom_ready(frm.odom_ready),
		.arm_status_known(frm.arm_status_known),
		.armed(frm.armed),
		.prearm_known(frm.prearm_known),
		.prearm_ok(frm.prearm_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stage(stage),
		.arm_request(arm_request),
		.arm_request_value(arm_request_value),
		.controller_action(controller_action),
		.controller_mode(controller_mode),
		.mode_invalid(mode_invalid),
		.arm_gesture(arm_gesture),
		.disarm_gesture(disarm_gesture),
		.waiting_for(waiting_for),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic result_t sequence_frame(frame_t f);
		result_t r;
		int thr;
		int ro;
		int pi;
		int ya;
		int th;
		logic centred;
		logic throttle_low;
		logic g;
		logic [31:0] elapsed;
		r = '0;
		thr = int'(thr_cfg);
		ro = $signed(f.roll);
		pi = $signed(f.pitch);
		ya = $signed(f.yaw);
		th = $signed(f.throttle);
		centred = ((ro < 0 ? -ro : ro) < thr) && ((pi < 0 ? -pi : pi) < thr);
		throttle_low = th < thr - Q_ONE;
		if (!f.rc_enable) begin
			sq_stage = STAGE_CODE_CHECK;
		end else begin
			case (sq_stage)
				STAGE_CODE_CHECK: begin
					if (!f.odom_ready) r.waiting_for = WAIT_ODOM;
					else if (!f.arm_status_known) r.waiting_for = WAIT_ARMST;
					else if (!f.prearm_known) r.waiting_for = WAIT_PREARM;
					else begin
						sq_arm_t0 = f.stamp_ms;
						sq_stage = STAGE_CODE_WAIT;
					end
				end
				STAGE_CODE_WAIT: begin
					elapsed = f.stamp_ms - sq_arm_t0;
					if (f.armed) begin
						sq_stage = STAGE_CODE_FIRST;
					end else if (elapsed > 32'(arm_hold_cfg)) begin
						r.arm_request = 1'b1;
						r.arm_request_value = 1'b1;
						sq_arm_t0 = f.stamp_ms;
					end else begin
						g = centred && ya < thr - Q_ONE && throttle_low;
						r.arm_gesture = g;
						if (!(g && f.prearm_ok)) sq_arm_t0 = f.stamp_ms;
					end
				end
				STAGE_CODE_FIRST: begin
					if (f.mode_request >= NUM_MODES) begin
						r.mode_invalid = 1'b1;
					end else begin
						r.controller_action = ACT_RESET;
						r.controller_mode = f.mode_request[3:0];
						sq_last_mode = f.mode_request[3:0];
						sq_disarm_t0 = f.stamp_ms;
						sq_stage = STAGE_CODE_RUN;
					end
				end
				STAGE_CODE_RUN: begin
					if (!f.armed) begin
						sq_stage = STAGE_CODE_WAIT;
					end else begin
						g = centred && ya > Q_ONE - thr && throttle_low;
						if (g) begin
							r.disarm_gesture = 1'b1;
							elapsed = f.stamp_ms - sq_disarm_t0;
							if (elapsed > 32'(disarm_hold_cfg)) begin
								r.arm_request = 1'b1;
								sq_disarm_t0 = f.stamp_ms;
							end
						end else begin
							sq_disarm_t0 = f.stamp_ms;
							if (f.mode_request >= NUM_MODES) begin
								r.mode_invalid = 1'b1;
							end else if (f.mode_request[3:0] != sq_last_mode) begin
								sq_last_mode = f.mode_request[3:0];
								r.controller_action = ACT_RESET;
								r.controller_mode = f.mode_request[3:0];
							end else begin
								r.controller_action = ACT_UPDATE;
								r.controller_mode = f.mode_request[3:0];
							end
						end
					end
				end
			endcase
		end
		r.stage = sq_stage;
		return r;
	endfunction

	function automatic frame_t mk_frame(logic en, logic [31:0] st, int ro, int pi, int ya,
			int th, logic [7:0] md, logic [4:0] fl);
		frame_t f;
		f.rc_enable = en;
		f.stamp_ms = st;
		f.roll = ro[15:0];
		f.pitch = pi[15:0];
		f.yaw = ya[15:0];
		f.throttle = th[15:0];
		f.mode_request = md;
		{f.odom_ready, f.arm_status_known, f.armed, f.prearm_known, f.prearm_ok} = fl;
		return f;
	endfunction

	function automatic int jitter(int j);
		int v;
		v = $urandom_range(0, j);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			CFG_STICK_THR: thr_cfg = val[THR_W-1:0];
			CFG_ARM_HOLD: arm_hold_cfg = val;
			CFG_DISARM_HOLD: disarm_hold_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int thr, int arm_ms, int disarm_ms);
		write_reg(CFG_STICK_THR, 16'(thr));
		write_reg(CFG_ARM_HOLD, 16'(arm_ms));
		write_reg(CFG_DISARM_HOLD, 16'(disarm_ms));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (frame_q.size() != 0 || in_valid || result_words_due.size() != 0);
	endtask

	// Gestures persist over several frames so that hold times can run out.
	task automatic gen_phase(int n);
		frame_t f;
		int step_max;
		int jmax;
		int j;
		step_max = (arm_hold_cfg > disarm_hold_cfg ? int'(arm_hold_cfg) : int'(disarm_hold_cfg))
			/ 3 + 2;
		jmax = int'(thr_cfg) + 3;
		if (jmax > Q_ONE) jmax = Q_ONE;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0) g_stamp = $urandom;
			else g_stamp = g_stamp + $urandom_range(0, step_max);
			if ($urandom_range(0, 11) == 0) g_armed = ~g_armed;
			if ($urandom_range(0, 4) == 0) g_kind = $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) g_mode = 8'($urandom_range(0, NUM_MODES - 1));
			j = $urandom_range(0, jmax);
			f.rc_enable = $urandom_range(0, 39) != 0;
			f.stamp_ms = g_stamp;
			f.odom_ready = $urandom_range(0, 9) != 0;
			f.arm_status_known = $urandom_range(0, 9) != 0;
			f.armed = g_armed;
			f.prearm_known = $urandom_range(0, 9) != 0;
			f.prearm_ok = $urandom_range(0, 7) != 0;
			f.mode_request = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_MODES, 255))
				: g_mode;
			if (g_kind == 2) begin
				f.roll = 16'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
				f.pitch = 16'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
				f.yaw = 16'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
				f.throttle = 16'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
			end else begin
				f.roll = 16'(jitter(j));
				f.pitch = 16'(jitter(j));
				f.throttle = 16'($urandom_range(0, j) - Q_ONE);
				if (g_kind == 0) f.yaw = 16'($urandom_range(0, j) - Q_ONE);
				else f.yaw = 16'(Q_ONE - $urandom_range(0, j));
			end
			frame_q.push_back(f);
		end
	endtask

	task automatic check_field(string name, logic [3:0] expv, logic [3:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				in_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (arst_n && frame_q.size() != 0) begin
				frm <= frame_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			out_gap = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_fire = in_valid && !in_stall;
		if (in_fire) result_words_due.push_back(sequence_frame(frm));
	end

	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			if (result_words_due.size() == 0) begin
				$error("result word with no frame waiting for it");
				errors++;
			end else begin
				want = result_words_due.pop_front();
				check_field("stage", 4'(want.stage), 4'(stage));
				check_field("arm_request", 4'(want.arm_request), 4'(arm_request));
				check_field("arm_request_value", 4'(want.arm_request_value),
					4'(arm_request_value));
				check_field("controller_action", 4'(want.controller_action),
					4'(controller_action));
				check_field("controller_mode", want.controller_mode, controller_mode);
				check_field("mode_invalid", 4'(want.mode_invalid), 4'(mode_invalid));
				check_field("arm_gesture", 4'(want.arm_gesture), 4'(arm_gesture));
				check_field("disarm_gesture", 4'(want.disarm_gesture), 4'(disarm_gesture));
				check_field("waiting_for", 4'(want.waiting_for), 4'(waiting_for));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk through every stage once with the reset configuration.
		frame_q.push_back(mk_frame(1'b0, 0, 0, 0, 0, 0, 0, FL_NONE));
		frame_q.push_back(mk_frame(1'b1, 10, 0, 0, 0, 0, 0, FL_NO_ODOM));
		frame_q.push_back(mk_frame(1'b1, 20, 0, 0, 0, 0, 0, FL_NO_ARMST));
		frame_q.push_back(mk_frame(1'b1, 30, 0, 0, 0, 0, 0, FL_NO_PRE));
		frame_q.push_back(mk_frame(1'b1, 100, 0, 0, 0, 0, 0, FL_READY));
		frame_q.push_back(mk_frame(1'b1, 2000, 0, 0, -Q_ONE, -Q_ONE, 0, FL_READY));
		frame_q.push_back(mk_frame(1'b1, 5100, 818, -818, 818 - Q_ONE, 818 - Q_ONE, 0,
			FL_READY));
		frame_q.push_back(mk_frame(1'b1, 5101, 5, 5, 5, 5, 0, FL_READY));
		frame_q.push_back(mk_frame(1'b1, 5200, 819, 0, -Q_ONE, -Q_ONE, 0, FL_READY));
		frame_q.push_back(mk_frame(1'b1, 5300, 0, 0, -Q_ONE, -Q_ONE, 0, FL_PRE_FAIL));
		frame_q.push_back(mk_frame(1'b1, 5400, 0, 0, 0, 0, 0, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 5500, 0, 0, 0, 0, 200, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 5600, 0, 0, 0, 0, 3, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 5700, 100, -100, 0, 0, 3, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 5800, 0, 0, 0, 0, 1, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 6800, 0, 0, Q_ONE, -Q_ONE, 1, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 7801, 0, 0, Q_ONE, -Q_ONE, 1, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 7900, 0, 0, 0, 0, 255, FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 8000, 0, 0, 0, 0, 1, FL_READY));
		frame_q.push_back(mk_frame(1'b0, 32'hFFFF_FFFF, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, 255,
			FL_ARMED));
		frame_q.push_back(mk_frame(1'b1, 32'hFFFF_FFFF, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 8'hAA,
			FL_READY));
		// The hold time runs out across the wrap of the millisecond counter.
		frame_q.push_back(mk_frame(1'b1, 5000, 0, 0, -Q_ONE, -Q_ONE, 0, FL_READY));
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(0, 0, 0);
				1: set_config(Q_ONE, 65535, 65535);
				2: set_config(THR_RESET, ARM_RESET, DISARM_RESET);
				default: set_config($urandom_range(100, 3000), $urandom_range(0, 3000),
					$urandom_range(0, 3000));
			endcase
			if (ph == 3) hold_req = 1'b1;
			if (ph == 7) quiet = 1'b1;
			gen_phase(60);
			drain();
		end

		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
